>>> rtl/core/jsu_pkg.sv
// shared types, codes and helpers for the json string unescaper
package jsu_pkg;

    localparam int ByteW = 8;

    typedef enum logic [2:0] {
        MODE_PLAIN  = 3'd0,
        MODE_ESCAPE = 3'd1,
        MODE_HEX0   = 3'd2,
        MODE_HEX1   = 3'd3,
        MODE_HEX2   = 3'd4,
        MODE_HEX3   = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_CLOSE = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    localparam logic [ByteW-1:0] ChNul    = 8'h00;
    localparam logic [ByteW-1:0] ChQuote  = 8'h22;
    localparam logic [ByteW-1:0] ChBslash = 8'h5C;
    localparam logic [ByteW-1:0] ChSlash  = 8'h2F;
    localparam logic [ByteW-1:0] ChB      = 8'h62;
    localparam logic [ByteW-1:0] ChF      = 8'h66;
    localparam logic [ByteW-1:0] ChN      = 8'h6E;
    localparam logic [ByteW-1:0] ChR      = 8'h72;
    localparam logic [ByteW-1:0] ChT      = 8'h74;
    localparam logic [ByteW-1:0] ChU      = 8'h75;

    // outcome of decoding one word against the current state
    typedef struct packed {
        logic             emit;
        logic [ByteW-1:0] data;
        kind_t            kind;
        mode_t            mode_next;
        logic [ByteW-1:0] accum_next;
    } dec_res_t;

    // hex digit check, both letter cases; bit 4 flags a valid digit
    function automatic logic [4:0] hex_nibble(input logic [ByteW-1:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

endpackage

>>> rtl/core/jsu_decode.sv
// combinational decode of one word against the escape state
module jsu_decode (
    input  jsu_pkg::mode_t            mode,
    input  logic [jsu_pkg::ByteW-1:0] accum,
    input  logic [jsu_pkg::ByteW-1:0] ch,
    output jsu_pkg::dec_res_t         res
);
    import jsu_pkg::*;

    logic [4:0]       nib;
    logic [ByteW-1:0] shifted;

    assign nib     = hex_nibble(ch);
    assign shifted = {accum[3:0], nib[3:0]};

    always_comb
    begin
        res.emit       = 1'b0;
        res.data       = '0;
        res.kind       = KIND_BYTE;
        res.mode_next  = mode;
        res.accum_next = accum;
        if (ch == ChNul) begin
            res.emit       = 1'b1;
            res.kind       = KIND_ERROR;
            res.mode_next  = MODE_PLAIN;
            res.accum_next = '0;
        end else begin
            case (mode)
                MODE_ESCAPE:
                begin
                    res.emit      = 1'b1;
                    res.mode_next = MODE_PLAIN;
                    case (ch)
                        ChQuote:  res.data = ChQuote;
                        ChBslash: res.data = ChBslash;
                        ChSlash:  res.data = ChSlash;
                        ChB:      res.data = 8'h08;
                        ChF:      res.data = 8'h0C;
                        ChN:      res.data = 8'h0A;
                        ChR:      res.data = 8'h0D;
                        ChT:      res.data = 8'h09;
                        ChU:
                        begin
                            res.emit       = 1'b0;
                            res.mode_next  = MODE_HEX0;
                            res.accum_next = '0;
                        end
                        default:
                        begin
                            res.kind       = KIND_ERROR;
                            res.accum_next = '0;
                        end
                    endcase
                end
                MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3:
                begin
                    if (!nib[4]) begin
                        res.emit       = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.mode_next  = MODE_PLAIN;
                        res.accum_next = '0;
                    end else if (mode == MODE_HEX3) begin
                        res.emit       = 1'b1;
                        res.data       = shifted;
                        res.mode_next  = MODE_PLAIN;
                        res.accum_next = '0;
                    end else begin
                        res.accum_next = shifted;
                        res.mode_next  = mode_t'(mode + 3'd1);
                    end
                end
                default:
                begin
                    // plain body, unused codes behave the same
                    res.mode_next = MODE_PLAIN;
                    if (ch == ChBslash) begin
                        res.mode_next = MODE_ESCAPE;
                    end else if (ch == ChQuote) begin
                        res.emit       = 1'b1;
                        res.kind       = KIND_CLOSE;
                        res.accum_next = '0;
                    end else begin
                        res.emit = 1'b1;
                        res.data = ch;
                    end
                end
            endcase
        end
    end

endmodule

>>> rtl/core/json_string_unescaper.sv
// top level of the json string unescaper
//
// channel | direction | handshake            | payload
// --------+-----------+----------------------+-------------------------
// in      | input     | in_valid / in_ready  | in_byte[7:0]
// out     | output    | out_valid / out_ready| out_byte[7:0], kind[1:0]
//
// one word a cycle while the output is not stalled; out_valid is registered
// the rate is set by the mode/hex accumulator loop, updated once per word
// rst_n clears the valid flags, mode (plain body) and the hex accumulator
// a stalled output holds; words that give no result keep flowing behind it
module json_string_unescaper (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [jsu_pkg::ByteW-1:0]     in_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [jsu_pkg::ByteW-1:0]     out_byte,
    output logic [1:0]                    kind
);
    import jsu_pkg::*;

    // input register stage
    logic             s1_valid_reg;
    logic [ByteW-1:0] s1_byte_reg;

    // escape state
    mode_t            mode_reg;
    logic [ByteW-1:0] accum_reg;

    // result register
    logic             out_valid_reg;
    logic [ByteW-1:0] out_byte_reg;
    kind_t            kind_reg;

    dec_res_t dec;
    logic     s1_adv;
    logic     in_take;

    jsu_decode u_decode (
        .mode  (mode_reg),
        .accum (accum_reg),
        .ch    (s1_byte_reg),
        .res   (dec)
    );

    // a word leaves stage one when it needs no output slot or the slot frees
    assign s1_adv   = s1_valid_reg && (!dec.emit || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_take  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (in_ready) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take) begin
            s1_byte_reg <= in_byte;
        end
    end

    // state advances once per decoded word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= MODE_PLAIN;
            accum_reg <= '0;
        end else if (s1_adv) begin
            mode_reg  <= dec.mode_next;
            accum_reg <= dec.accum_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (s1_adv && dec.emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && dec.emit) begin
            out_byte_reg <= dec.data;
            kind_reg     <= dec.kind;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign kind      = kind_reg;

`ifndef ASSERT_OFF
    // a close or an error always returns to plain body with a clear accumulator
    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && dec.emit && dec.kind != KIND_BYTE)
        |=> (mode_reg == MODE_PLAIN && accum_reg == '0))
        else $error("state not cleared after close or error");

    // a nul word always produces an error result
    a_nul_error: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_byte_reg == ChNul)
        |=> (out_valid_reg && kind_reg == KIND_ERROR))
        else $error("nul word did not report an error");

    // non-byte results carry a zero data byte
    a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg != KIND_BYTE) |-> (out_byte_reg == '0))
        else $error("close or error result carries data");

    // a held result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !(s1_adv && dec.emit))
        else $error("stalled result overwritten");
`endif

endmodule

>>> dv/tb_top.sv
// self-checking testbench for the json string unescaper
module tb_top;
    import jsu_pkg::*;

    // run length guard, far above the slowest legal run of about 800 words
    localparam int CycleLimit  = 200000;
    localparam int RandomWords = 750;
    // idle odds, in percent, for both the sender and the receiver
    localparam int IdlePct     = 32;

    // one decoded outcome as the output channel should present it
    typedef struct {
        logic [ByteW-1:0] data;
        kind_t            kind;
    } decoded_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    logic [ByteW-1:0] in_byte   = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [ByteW-1:0] out_byte;
    logic [1:0]       kind;

    logic [ByteW-1:0] byte_feed[$];        // words waiting for the driver
    decoded_t         expected_q[$];       // outcomes not yet seen on the output
    int               words_queued = 0;
    int               words_taken  = 0;
    int               cycle_count  = 0;
    int               fail_count   = 0;
    int               seen_bytes   = 0;
    int               seen_closes  = 0;
    int               seen_errors  = 0;
    logic             calm;

    // decoder state mirrored by the testbench
    mode_t            dec_mode  = MODE_PLAIN;
    logic [ByteW-1:0] dec_accum = '0;

    // the eight single-letter escapes, in the order quote, backslash, slash, b f n r t
    logic [ByteW-1:0] esc_letters[8] = '{ChQuote, ChBslash, ChSlash, ChB, ChF, ChN, ChR, ChT};

    json_string_unescaper u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .kind      (kind)
    );

    always #5 clk = ~clk;

    // a window with no idling on either side, so back-to-back traffic gets a long run
    assign calm = (cycle_count >= 500) && (cycle_count < 1100);

    // value of a hex digit of either case, or -1 for anything else
    function automatic int hex_value(input logic [ByteW-1:0] c);
        if (c >= 8'h30 && c <= 8'h39)
        begin
            return int'(c) - 'h30;
        end
        if (c >= 8'h41 && c <= 8'h46)
        begin
            return int'(c) - 'h41 + 10;
        end
        if (c >= 8'h61 && c <= 8'h66)
        begin
            return int'(c) - 'h61 + 10;
        end
        return -1;
    endfunction

    // advance the mirrored decoder by one word; returns 1 when the word yields an outcome
    function automatic bit decode_word(input logic [ByteW-1:0] c,
                                       output logic [ByteW-1:0] d, output kind_t k);
        int  nib;
        bit  got;
        d   = '0;
        k   = KIND_BYTE;
        got = 1'b1;
        nib = hex_value(c);
        if (c == ChNul)
        begin
            // end of buffer truncates the string in every mode
            k = KIND_ERROR;
        end
        else
        begin
            case (dec_mode)
                MODE_ESCAPE:
                begin
                    dec_mode = MODE_PLAIN;
                    case (c)
                        ChQuote, ChBslash, ChSlash: d = c;
                        ChB: d = 8'h08;     // backspace
                        ChF: d = 8'h0C;     // form feed
                        ChN: d = 8'h0A;     // line feed
                        ChR: d = 8'h0D;     // carriage return
                        ChT: d = 8'h09;     // tab
                        ChU:
                        begin
                            dec_mode  = MODE_HEX0;
                            dec_accum = '0;
                            got       = 1'b0;
                        end
                        default: k = KIND_ERROR;
                    endcase
                end
                MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3:
                begin
                    if (nib < 0)
                    begin
                        k = KIND_ERROR;
                    end
                    else
                    begin
                        // only the low two digits survive in the 8-bit accumulator
                        dec_accum = {dec_accum[3:0], nib[3:0]};
                        if (dec_mode == MODE_HEX3)
                        begin
                            d         = dec_accum;
                            dec_mode  = MODE_PLAIN;
                            dec_accum = '0;
                        end
                        else
                        begin
                            dec_mode = mode_t'(dec_mode + 1);
                            got      = 1'b0;
                        end
                    end
                end
                default:
                begin
                    dec_mode = MODE_PLAIN;
                    if (c == ChBslash)
                    begin
                        dec_mode = MODE_ESCAPE;
                        got      = 1'b0;
                    end
                    else if (c == ChQuote)
                    begin
                        k = KIND_CLOSE;
                    end
                    else
                    begin
                        d = c;
                    end
                end
            endcase
        end
        // a close or an error always leaves the decoder ready for a fresh string
        if (got && k != KIND_BYTE)
        begin
            dec_mode  = MODE_PLAIN;
            dec_accum = '0;
        end
        return got;
    endfunction

    task automatic queue_word(input logic [ByteW-1:0] b);
        byte_feed.insert(byte_feed.size(), b);
        words_queued++;
    endtask

    // hex digit character for a nibble, letters in a random case
    function automatic logic [ByteW-1:0] hex_char(input int n);
        if (n < 10)
        begin
            return ByteW'(8'h30 + n);
        end
        return ByteW'(($urandom_range(1) ? 8'h41 : 8'h61) + n - 10);
    endfunction

    // any non-zero byte that is neither a quote nor a backslash, control bytes included
    function automatic logic [ByteW-1:0] plain_byte();
        logic [ByteW-1:0] b;
        do
        begin
            b = ByteW'($urandom_range(1, 255));
        end
        while (b == ChQuote || b == ChBslash);
        return b;
    endfunction

    // a non-zero byte that no escape accepts
    function automatic logic [ByteW-1:0] bad_escape();
        logic [ByteW-1:0] b;
        bit               known;
        do
        begin
            b     = ByteW'($urandom_range(1, 255));
            known = (b == ChU);
            foreach (esc_letters[i])
            begin
                if (b == esc_letters[i])
                begin
                    known = 1'b1;
                end
            end
        end
        while (known);
        return b;
    endfunction

    // a non-zero byte that is not a hex digit
    function automatic logic [ByteW-1:0] bad_hex();
        logic [ByteW-1:0] b;
        do
        begin
            b = ByteW'($urandom_range(1, 255));
        end
        while (hex_value(b) >= 0);
        return b;
    endfunction

    // one string body: mostly well formed with a closing quote, now and then broken
    task automatic queue_random_string();
        int units;
        int pick;
        units = $urandom_range(12);
        for (int i = 0; i < units; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                queue_word(plain_byte());
            end
            else if (pick < 75)
            begin
                queue_word(ChBslash);
                queue_word(esc_letters[$urandom_range(7)]);
            end
            else if (pick < 95)
            begin
                queue_word(ChBslash);
                queue_word(ChU);
                repeat (4) queue_word(hex_char($urandom_range(15)));
            end
            else
            begin
                // raw noise, any value at all
                queue_word(ByteW'($urandom_range(255)));
            end
        end
        pick = $urandom_range(99);
        if (pick < 84)
        begin
            queue_word(ChQuote);
        end
        else if (pick < 88)
        begin
            queue_word(ChNul);
        end
        else if (pick < 92)
        begin
            queue_word(ChBslash);
            queue_word(bad_escape());
        end
        else
        begin
            // unicode escape cut short by a bad digit or by end of buffer
            queue_word(ChBslash);
            queue_word(ChU);
            repeat ($urandom_range(3)) queue_word(hex_char($urandom_range(15)));
            queue_word(pick < 96 ? bad_hex() : ChNul);
        end
    endtask

    // hold off until every queued word is in and every outcome has come out
    task automatic wait_drained();
        while (words_taken != words_queued || expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        // room for the input and result registers to drain, so a stray extra word would still be caught
        repeat (6) @(posedge clk);
    endtask

    // sender and receiver; valid holds with its word until accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            in_byte   <= '0;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= calm || ($urandom_range(99) >= IdlePct);
            if (!in_valid || in_ready)
            begin
                if (byte_feed.size() != 0 && (calm || $urandom_range(99) >= IdlePct))
                begin
                    in_valid <= 1'b1;
                    in_byte  <= byte_feed.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each output word against the oldest outcome, then predicts
    // from the input word taken at this edge (its outcome cannot appear at the same edge)
    always @(posedge clk)
    begin : monitor
        decoded_t         want;
        logic [ByteW-1:0] d;
        kind_t            k;
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            if (out_valid && out_ready)
            begin
                case (kind)
                    KIND_BYTE:  seen_bytes++;
                    KIND_CLOSE: seen_closes++;
                    default:    seen_errors++;
                endcase
                if (expected_q.size() == 0)
                begin
                    $error("unexpected output word: out_byte %02h kind %0d", out_byte, kind);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (kind !== want.kind)
                    begin
                        $error("kind mismatch: expected %0d, actual %0d", want.kind, kind);
                        fail_count++;
                    end
                    if (out_byte !== want.data)
                    begin
                        $error("out_byte mismatch: expected %02h, actual %02h",
                               want.data, out_byte);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                words_taken++;
                if (decode_word(in_byte, d, k))
                begin
                    want.data = d;
                    want.kind = k;
                    expected_q.insert(expected_q.size(), want);
                end
            end
            if (cycle_count >= CycleLimit)
            begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extreme and control bytes pass straight through
        queue_word(8'h01);
        queue_word(8'hFF);
        // every single-letter escape
        foreach (esc_letters[i])
        begin
            queue_word(ChBslash);
            queue_word(esc_letters[i]);
        end
        // unicode escape, mixed case, low byte 0x9f
        queue_word(ChBslash);
        queue_word(ChU);
        queue_word(8'h61);      // a
        queue_word(8'h46);      // F
        queue_word(8'h39);      // 9
        queue_word(8'h66);      // f
        // unicode escape whose low byte is zero still yields a decoded byte
        queue_word(ChBslash);
        queue_word(ChU);
        queue_word(8'h42);      // B
        queue_word(8'h37);      // 7
        queue_word(8'h30);
        queue_word(8'h30);
        // closing quote
        queue_word(ChQuote);
        // unknown escape letter
        queue_word(ChBslash);
        queue_word(8'h71);      // q
        // bad hex digit part way through a unicode escape
        queue_word(ChBslash);
        queue_word(ChU);
        queue_word(8'h31);
        queue_word(8'h67);      // g
        // end of buffer in plain body, after a backslash and inside a unicode escape
        queue_word(ChNul);
        queue_word(ChBslash);
        queue_word(ChNul);
        queue_word(ChBslash);
        queue_word(ChU);
        queue_word(8'h45);
        queue_word(ChNul);

        // sender stops here until the directed outcomes have all arrived
        wait_drained();

        begin : random_part
            int target;
            target = words_queued + RandomWords;
            while (words_queued < target)
            begin
                queue_random_string();
            end
        end

        wait_drained();

        $display("tb_top: %0d words in, %0d decoded bytes, %0d closed strings, %0d errors",
                 words_taken, seen_bytes, seen_closes, seen_errors);
        $display("tb_top: directed escapes and truncations, then random strings with noise");
        if (fail_count == 0)
        begin
            $display("tb_top: PASS");
        end
        else
        begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
